// ----- design/jtft_pkg.sv -----
`default_nettype none

package jtft_pkg;

	// request codes
	localparam logic [1:0] REQ_DISPATCH = 2'd0;
	localparam logic [1:0] REQ_ACK      = 2'd1;
	localparam logic [1:0] REQ_CHECK    = 2'd2;

	// configuration register indexes
	localparam logic CFG_TIMEOUT_BASE = 1'b0;
	localparam logic CFG_RATE_SHIFT   = 1'b1;

	// configuration reset values and field widths
	localparam logic [7:0] TIMEOUT_BASE_RST = 8'd5;
	localparam logic [5:0] RATE_SHIFT_RST   = 6'd27;
	localparam int         CFG_W            = 8;
	localparam int         WORD_W           = 32;

	typedef enum logic [2:0] {
		KIND_DISPATCHED  = 3'd0,
		KIND_COMPLETED   = 3'd1,
		KIND_UNKNOWN_ACK = 3'd2,
		KIND_REASSIGNED  = 3'd3,
		KIND_NO_SPARE    = 3'd4,
		KIND_NONE_LATE   = 3'd5
	} result_kind_t;

	// controller to datapath
	typedef struct packed {
		logic         load;
		logic         scan_clear;
		logic         scan_run;
		logic         late_take;
		logic         spare_take;
		logic         ack_commit;
		logic         sum_calc;
		logic         move;
		logic         assign_wr;
		logic         emit;
		result_kind_t kind;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] req_code;
		logic       slot_ok;
		logic       ack_hit;
		logic       late_hit;
		logic       spare_hit;
		logic       scan_end;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- design/jtft_ram.sv -----
`default_nettype none

module jtft_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- design/jtft_ctrl.sv -----
`default_nettype none

module jtft_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire jtft_pkg::dp_stat_t stat,
	output jtft_pkg::dp_cmd_t       cmd
);

	import jtft_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ACK   = 8'b0000_0010,
		S_LATE  = 8'b0000_0100,
		S_SPARE = 8'b0000_1000,
		S_DSUM  = 8'b0001_0000,
		S_DWR   = 8'b0010_0000,
		S_MSUM  = 8'b0100_0000,
		S_MWR   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != S_IDLE);

	// next state and datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (stat.req_code)
						REQ_DISPATCH: begin
							if (stat.slot_ok) begin
								state_d = S_DSUM;
							end
						end
						REQ_ACK: begin
							cmd.scan_clear = 1'b1;
							state_d        = S_ACK;
						end
						REQ_CHECK: begin
							cmd.scan_clear = 1'b1;
							state_d        = S_LATE;
						end
						default: ;
					endcase
				end
			end
			S_ACK: begin
				cmd.scan_run = 1'b1;
				if (stat.ack_hit) begin
					cmd.ack_commit = 1'b1;
					cmd.emit       = 1'b1;
					cmd.kind       = KIND_COMPLETED;
					state_d        = S_IDLE;
				end else if (stat.scan_end) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_UNKNOWN_ACK;
					state_d  = S_IDLE;
				end
			end
			S_LATE: begin
				cmd.scan_run = 1'b1;
				if (stat.late_hit) begin
					cmd.late_take  = 1'b1;
					cmd.scan_clear = 1'b1;
					state_d        = S_SPARE;
				end else if (stat.scan_end) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_NONE_LATE;
					state_d  = S_IDLE;
				end
			end
			S_SPARE: begin
				cmd.scan_run = 1'b1;
				if (stat.spare_hit) begin
					cmd.spare_take = 1'b1;
					state_d        = S_MSUM;
				end else if (stat.scan_end) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_NO_SPARE;
					state_d  = S_IDLE;
				end
			end
			S_DSUM: begin
				cmd.sum_calc = 1'b1;
				state_d      = S_DWR;
			end
			S_DWR: begin
				cmd.assign_wr = 1'b1;
				cmd.emit      = 1'b1;
				cmd.kind      = KIND_DISPATCHED;
				state_d       = S_IDLE;
			end
			S_MSUM: begin
				cmd.move     = 1'b1;
				cmd.sum_calc = 1'b1;
				state_d      = S_MWR;
			end
			S_MWR: begin
				cmd.move      = 1'b1;
				cmd.assign_wr = 1'b1;
				cmd.emit      = 1'b1;
				cmd.kind      = KIND_REASSIGNED;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/jtft_dp.sv -----
`default_nettype none

module jtft_dp #(
	parameter int SLOTS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [jtft_pkg::CFG_W-1:0] cfg_data,
	input  wire logic [1:0]                 req_type,
	input  wire logic [2:0]                 slot,
	input  wire logic [31:0]                job_size,
	input  wire logic [31:0]                job_offset,
	input  wire logic [31:0]                ack_id,
	input  wire logic [31:0]                now,
	input  wire jtft_pkg::dp_cmd_t          cmd,
	output jtft_pkg::dp_stat_t              stat,
	output logic                            result_valid,
	output logic [2:0]                      result_kind,
	output logic [2:0]                      client,
	output logic [2:0]                      spare_client,
	output logic [31:0]                     out_size,
	output logic [31:0]                     out_offset,
	output logic [31:0]                     wait_id,
	output logic [31:0]                     send_id,
	output logic [31:0]                     deadline,
	output logic                            all_done
);

	import jtft_pkg::*;

	localparam int             SW      = $clog2(SLOTS);
	localparam int             EW      = SW + 3;
	localparam int             CW      = $clog2(SLOTS + 1);
	localparam logic [SW-1:0]  LAST    = SW'(SLOTS - 1);
	localparam logic [CW-1:0]  CNT_MAX = CW'(SLOTS);
	localparam logic [EW-1:0]  SLOT_LIM = EW'(SLOTS);

	// configuration
	logic [7:0]        base_q;
	logic [5:0]        shift_q;

	// latched request
	logic [SW-1:0]     slot_q;
	logic [31:0]       size_q;
	logic [31:0]       offset_q;
	logic [31:0]       ack_q;
	logic [31:0]       now_q;

	// slot state held in flops
	logic [31:0]       next_id_q;
	logic [CW-1:0]     done_cnt_q;
	logic [SLOTS-1:0]  fin_q;
	logic [SLOTS-1:0]  brk_q;
	logic [SLOTS-1:0]  vld_q;

	// scan engine
	logic [SW-1:0]     addr_q;
	logic              issue_q;
	logic              rd_vld_s1;
	logic [SW-1:0]     rd_idx_s1;
	logic [SW-1:0]     late_q;
	logic [SW-1:0]     spare_q;
	logic [31:0]       sum_q;

	// table ports
	logic [63:0]       ida_rd;
	logic [63:0]       job_rd;
	logic [SW-1:0]     tgt;
	logic [31:0]       new_dl;

	logic [EW-1:0]     slot_ext;
	logic [31:0]       rd_wait;
	logic [31:0]       rd_dl;
	logic [31:0]       src_size;
	logic [31:0]       src_off;
	logic [31:0]       extra;
	logic [CW-1:0]     done_nxt;

	logic [EW-1:0]     slot_x;
	logic [EW-1:0]     idx_x;
	logic [EW-1:0]     late_x;
	logic [EW-1:0]     spare_x;

	// result staging
	logic [2:0]        cl_d;
	logic [2:0]        sp_d;
	logic [31:0]       sz_d;
	logic [31:0]       of_d;
	logic [31:0]       wt_d;
	logic [31:0]       sd_d;
	logic [31:0]       dl_d;

	logic              result_valid_q;
	result_kind_t      kind_q;
	logic [2:0]        client_q;
	logic [2:0]        spare_q_out;
	logic [31:0]       size_out_q;
	logic [31:0]       offset_out_q;
	logic [31:0]       wait_q;
	logic [31:0]       send_q;
	logic [31:0]       dl_out_q;
	logic              all_done_q;

	// waiting id and deadline per slot
	jtft_ram #(
		.WIDTH (64),
		.DEPTH (SLOTS)
	) u_ida_ram (
		.clk   (clk),
		.we    (cmd.assign_wr),
		.waddr (tgt),
		.wdata ({next_id_q, new_dl}),
		.raddr (addr_q),
		.rdata (ida_rd)
	);

	// job size and offset per slot, read at the late slot
	jtft_ram #(
		.WIDTH (64),
		.DEPTH (SLOTS)
	) u_job_ram (
		.clk   (clk),
		.we    (cmd.assign_wr),
		.waddr (tgt),
		.wdata ({src_size, src_off}),
		.raddr (late_q),
		.rdata (job_rd)
	);

	// request decode and scan compares
	always_comb begin
		slot_ext = EW'(slot);
		rd_wait  = vld_q[rd_idx_s1] ? ida_rd[63:32] : 32'd0;
		rd_dl    = vld_q[rd_idx_s1] ? ida_rd[31:0] : 32'd0;

		stat.req_code  = req_type;
		stat.slot_ok   = (slot_ext < SLOT_LIM);
		stat.ack_hit   = rd_vld_s1 && (rd_wait == ack_q);
		stat.late_hit  = rd_vld_s1 && !brk_q[rd_idx_s1] && !fin_q[rd_idx_s1]
			&& (rd_dl < now_q);
		stat.spare_hit = rd_vld_s1 && (rd_idx_s1 != late_q) && fin_q[rd_idx_s1]
			&& !brk_q[rd_idx_s1];
		stat.scan_end  = rd_vld_s1 && (rd_idx_s1 == LAST);
	end

	// job source, deadline and target
	always_comb begin
		src_size = cmd.move ? job_rd[63:32] : size_q;
		src_off  = cmd.move ? job_rd[31:0] : offset_q;
		extra    = (shift_q < 6'd32) ? (src_size >> shift_q) : 32'd0;
		tgt      = cmd.move ? spare_q : slot_q;
		new_dl   = now_q + sum_q;
		done_nxt = (cmd.ack_commit && (done_cnt_q < CNT_MAX)) ? done_cnt_q + 1'b1
			: done_cnt_q;
	end

	// result field selection
	always_comb begin
		slot_x  = EW'(slot_q);
		idx_x   = EW'(rd_idx_s1);
		late_x  = EW'(late_q);
		spare_x = EW'(spare_q);
		cl_d    = 3'd0;
		sp_d    = 3'd0;
		sz_d    = 32'd0;
		of_d    = 32'd0;
		wt_d    = 32'd0;
		sd_d    = 32'd0;
		dl_d    = 32'd0;
		case (cmd.kind)
			KIND_DISPATCHED: begin
				cl_d = slot_x[2:0];
				sz_d = src_size;
				of_d = src_off;
				wt_d = next_id_q;
				sd_d = next_id_q + 32'd1;
				dl_d = new_dl;
			end
			KIND_COMPLETED: begin
				cl_d = idx_x[2:0];
			end
			KIND_REASSIGNED: begin
				cl_d = late_x[2:0];
				sp_d = spare_x[2:0];
				sz_d = src_size;
				of_d = src_off;
				wt_d = next_id_q;
				sd_d = next_id_q + 32'd1;
				dl_d = new_dl;
			end
			KIND_NO_SPARE: begin
				cl_d = late_x[2:0];
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= TIMEOUT_BASE_RST;
			shift_q <= RATE_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT_BASE: base_q  <= cfg_data;
				CFG_RATE_SHIFT:   shift_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// request capture and deadline partial sum
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q   <= slot_ext[SW-1:0];
			size_q   <= job_size;
			offset_q <= job_offset;
			ack_q    <= ack_id;
			now_q    <= now;
		end
		if (cmd.sum_calc) begin
			sum_q <= extra + 32'(base_q);
		end
		if (cmd.late_take) begin
			late_q <= rd_idx_s1;
		end
		if (cmd.spare_take) begin
			spare_q <= rd_idx_s1;
		end
	end

	// slot marks, id counter and completion count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q  <= 32'd1;
			done_cnt_q <= '0;
			fin_q      <= '0;
			brk_q      <= '0;
			vld_q      <= '0;
		end else begin
			done_cnt_q <= done_nxt;
			if (cmd.ack_commit) begin
				fin_q[rd_idx_s1] <= 1'b1;
			end
			if (cmd.assign_wr) begin
				next_id_q  <= next_id_q + 32'd2;
				vld_q[tgt] <= 1'b1;
				fin_q[tgt] <= 1'b0;
				brk_q[tgt] <= 1'b0;
				if (cmd.move) begin
					brk_q[late_q] <= 1'b1;
				end
			end
		end
	end

	// scan address issue and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else if (cmd.scan_clear) begin
			addr_q    <= '0;
			issue_q   <= 1'b1;
			rd_vld_s1 <= 1'b0;
		end else if (cmd.scan_run) begin
			rd_vld_s1 <= issue_q;
			rd_idx_s1 <= addr_q;
			if (issue_q) begin
				if (addr_q == LAST) begin
					issue_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end else begin
			rd_vld_s1 <= 1'b0;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q       <= cmd.kind;
			client_q     <= cl_d;
			spare_q_out  <= sp_d;
			size_out_q   <= sz_d;
			offset_out_q <= of_d;
			wait_q       <= wt_d;
			send_q       <= sd_d;
			dl_out_q     <= dl_d;
			all_done_q   <= (done_nxt == CNT_MAX);
		end
	end

	assign result_valid = result_valid_q;
	assign result_kind  = kind_q;
	assign client       = client_q;
	assign spare_client = spare_q_out;
	assign out_size     = size_out_q;
	assign out_offset   = offset_out_q;
	assign wait_id      = wait_q;
	assign send_id      = send_q;
	assign deadline     = dl_out_q;
	assign all_done     = all_done_q;

endmodule

`default_nettype wire

// ----- design/job_timeout_failover_tracker.sv -----
`default_nettype none

// Tracks one job per worker slot with a waiting id, a deadline and finished and
// broken marks. A request is taken when start is high and busy is low; each
// dispatch, acknowledgement or timeout check gives one result, shown for exactly
// one cycle with result_valid high, and the receiver cannot hold it off (a
// dispatch to a slot at or beyond SLOTS or an unused request type gives none).
// Timing is set by the slot table, which has one read port and is scanned one
// slot per cycle: a dispatch does the deadline add and then the write, an
// acknowledgement at most one pass over the slots, and a timeout check one pass
// for the late slot, one for a spare, then the deadline add and the move.
// The waiting ids and deadlines read as zero until a slot is first written.
module job_timeout_failover_tracker #(
	parameter int SLOTS = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [jtft_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 req_type,
	input  wire logic [2:0]                 slot,
	input  wire logic [31:0]                job_size,
	input  wire logic [31:0]                job_offset,
	input  wire logic [31:0]                ack_id,
	input  wire logic [31:0]                now,
	output logic                            result_valid,
	output logic [2:0]                      result_kind,
	output logic [2:0]                      client,
	output logic [2:0]                      spare_client,
	output logic [31:0]                     out_size,
	output logic [31:0]                     out_offset,
	output logic [31:0]                     wait_id,
	output logic [31:0]                     send_id,
	output logic [31:0]                     deadline,
	output logic                            all_done
);

	import jtft_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing
	jtft_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// slot tables, scan engine and result registers
	jtft_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.slot         (slot),
		.job_size     (job_size),
		.job_offset   (job_offset),
		.ack_id       (ack_id),
		.now          (now),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_kind  (result_kind),
		.client       (client),
		.spare_client (spare_client),
		.out_size     (out_size),
		.out_offset   (out_offset),
		.wait_id      (wait_id),
		.send_id      (send_id),
		.deadline     (deadline),
		.all_done     (all_done)
	);

endmodule

`default_nettype wire
